// ===== sv/tpq_pkg.sv =====
// Shared types and constants for the timestamp priority queue.
`default_nettype none
package tpq_pkg;

  // Fixed field widths at the block boundary
  localparam int unsigned PROC_W    = 4;
  localparam int unsigned TIME_IN_W = 16;
  localparam int unsigned FILL_W    = 5;
  localparam int unsigned STATUS_W  = 2;

  // Operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

endpackage
`default_nettype wire

// ===== sv/timestamp_priority_queue_unit.sv =====
// Top level: sorted lock-request queue with an insert/shift sequencer.
//
// Usage: drive opcode_i (push or pop), req_time_i and req_proc_i with start_i
// high while busy_o is low; that edge accepts the command. Exactly one result
// beat follows: done_o is high for one cycle with status_o, entry_valid_o,
// entry_time_o, entry_proc_o and fill_count_o. The receiver cannot hold it
// off, so it must take the beat in that cycle.
// Push to a full queue and pop on an empty queue are answered the cycle
// after acceptance and leave the queue unchanged.
// A push walks down from the tail, one stored entry per cycle, moving larger
// entries up by one through the single compare unit until it finds its
// place, busy_o dropping with done_o. A pop answers the cycle after
// acceptance but stays busy while the rest shifts toward the head.
// The pace is set by the one memory read and one write per cycle; a new
// command is taken only once busy_o is low.
// Reset empties the queue at once; entry memory is not cleared.
`default_nettype none
module timestamp_priority_queue_unit #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned TIME_BITS = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  output      logic                             busy_o,
  input  wire logic                             opcode_i,
  input  wire logic [tpq_pkg::TIME_IN_W-1:0]    req_time_i,
  input  wire logic [tpq_pkg::PROC_W-1:0]       req_proc_i,
  output      logic                             done_o,
  output      logic [tpq_pkg::STATUS_W-1:0]     status_o,
  output      logic                             entry_valid_o,
  output      logic [tpq_pkg::TIME_IN_W-1:0]    entry_time_o,
  output      logic [tpq_pkg::PROC_W-1:0]       entry_proc_o,
  output      logic [tpq_pkg::FILL_W-1:0]       fill_count_o
);

  import tpq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned EW = TIME_BITS + PROC_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_INS  = 2'd1;
  localparam logic [1:0] ST_PUT  = 2'd2;
  localparam logic [1:0] ST_POP  = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [CW-1:0]        count_q, count_d;
  logic [AW-1:0]        pos_q, pos_d;
  logic [AW-1:0]        idx_q, idx_d;
  logic [TIME_BITS-1:0] req_time_q, req_time_d;
  logic [PROC_W-1:0]    req_proc_q, req_proc_d;
  logic [TIME_BITS-1:0] head_time_q, head_time_d;
  logic [PROC_W-1:0]    head_proc_q, head_proc_d;
  logic                 done_q, done_d;
  logic [STATUS_W-1:0]  status_q, status_d;
  logic                 valid_q, valid_d;
  logic [TIME_IN_W-1:0] time_q, time_d;
  logic [PROC_W-1:0]    proc_q, proc_d;
  logic [FILL_W-1:0]    fill_q, fill_d;

  logic [TIME_BITS-1:0] emit_time;
  logic [PROC_W-1:0]    emit_proc;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [EW-1:0]        mem_wdata;
  logic [AW-1:0]        mem_raddr;
  logic [EW-1:0]        mem_rdata;
  logic [TIME_BITS-1:0] rd_time;
  logic [PROC_W-1:0]    rd_proc;
  logic                 req_less;

  logic [TIME_BITS+TIME_IN_W-1:0] in_time_ext;
  logic [TIME_BITS+TIME_IN_W-1:0] out_time_ext;
  logic [CW+FILL_W-1:0]           fill_ext;

  // Entry storage
  tpq_store #(
    .DEPTH (DEPTH),
    .WIDTH (EW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign rd_time = mem_rdata[EW-1:PROC_W];
  assign rd_proc = mem_rdata[PROC_W-1:0];

  // Shared key compare: pending request against the entry just read
  tpq_key_cmp #(
    .TIME_BITS (TIME_BITS)
  ) u_cmp (
    .a_time_i (req_time_q),
    .a_proc_i (req_proc_q),
    .b_time_i (rd_time),
    .b_proc_i (rd_proc),
    .less_o   (req_less)
  );

  // Width fitting of the timestamp and fill count
  assign in_time_ext  = {{TIME_BITS{1'b0}}, req_time_i};
  assign out_time_ext = {{TIME_IN_W{1'b0}}, emit_time};
  assign fill_ext     = {{FILL_W{1'b0}}, count_d};
  assign time_d       = out_time_ext[TIME_IN_W-1:0];
  assign proc_d       = emit_proc;
  assign fill_d       = fill_ext[FILL_W-1:0];

  // Sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    idx_d       = idx_q;
    req_time_d  = req_time_q;
    req_proc_d  = req_proc_q;
    head_time_d = head_time_q;
    head_proc_d = head_proc_q;
    done_d      = 1'b0;
    status_d    = STATUS_OK;
    valid_d     = 1'b1;
    emit_time   = head_time_q;
    emit_proc   = head_proc_q;
    mem_we      = 1'b0;
    mem_waddr   = pos_q;
    mem_wdata   = {req_time_q, req_proc_q};
    mem_raddr   = '0;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          req_time_d = in_time_ext[TIME_BITS-1:0];
          req_proc_d = req_proc_i;
          if (opcode_i == OP_PUSH) begin
            if (count_q == CW'(DEPTH)) begin
              // full: drop, report current head
              done_d   = 1'b1;
              status_d = STATUS_FULL;
            end else if (count_q == '0) begin
              pos_d   = '0;
              state_d = ST_PUT;
            end else begin
              pos_d     = count_q[AW-1:0];
              mem_raddr = count_q[AW-1:0] - 1'b1;
              state_d   = ST_INS;
            end
          end else begin
            if (count_q == '0) begin
              done_d    = 1'b1;
              status_d  = STATUS_EMPTY;
              valid_d   = 1'b0;
              emit_time = '0;
              emit_proc = '0;
            end else begin
              // report head now, shift the rest down afterwards
              done_d  = 1'b1;
              count_d = count_q - 1'b1;
              if (count_q != CW'(1)) begin
                mem_raddr = AW'(1);
                idx_d     = '0;
                state_d   = ST_POP;
              end
            end
          end
        end
      end

      ST_INS: begin
        if (req_less) begin
          // move the larger entry up one place
          mem_we    = 1'b1;
          mem_waddr = pos_q;
          mem_wdata = mem_rdata;
          pos_d     = pos_q - 1'b1;
          if (pos_q == AW'(1)) begin
            state_d = ST_PUT;
          end else begin
            mem_raddr = pos_q - AW'(2);
          end
        end else begin
          // place found above the head
          mem_we  = 1'b1;
          count_d = count_q + 1'b1;
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end

      ST_PUT: begin
        // request lands at the head
        mem_we      = 1'b1;
        count_d     = count_q + 1'b1;
        head_time_d = req_time_q;
        head_proc_d = req_proc_q;
        emit_time   = req_time_q;
        emit_proc   = req_proc_q;
        done_d      = 1'b1;
        state_d     = ST_IDLE;
      end

      ST_POP: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q;
        mem_wdata = mem_rdata;
        if (idx_q == '0) begin
          head_time_d = rd_time;
          head_proc_d = rd_proc;
        end
        if ((CW'(idx_q) + 1'b1) == count_q) begin
          state_d = ST_IDLE;
        end else begin
          mem_raddr = idx_q + AW'(2);
          idx_d     = idx_q + 1'b1;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      pos_q   <= '0;
      idx_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pos_q   <= pos_d;
      idx_q   <= idx_d;
      done_q  <= done_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_time_q  <= req_time_d;
    req_proc_q  <= req_proc_d;
    head_time_q <= head_time_d;
    head_proc_q <= head_proc_d;
    if (done_d) begin
      status_q <= status_d;
      valid_q  <= valid_d;
      time_q   <= time_d;
      proc_q   <= proc_d;
      fill_q   <= fill_d;
    end
  end

  assign busy_o        = (state_q != ST_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign entry_valid_o = valid_q;
  assign entry_time_o  = time_q;
  assign entry_proc_o  = proc_q;
  assign fill_count_o  = fill_q;

  // Checks
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count beyond depth");

  a_full_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == STATUS_FULL |-> count_q == CW'(DEPTH))
    else $error("full status while queue has room");

  a_empty_pop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && opcode_i == OP_POP && count_q == '0
      |=> done_o && status_o == STATUS_EMPTY && !entry_valid_o)
    else $error("pop on empty queue not flagged");

  a_ok_has_entry : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == STATUS_OK |-> entry_valid_o)
    else $error("ok result without an entry");

  a_pop_walk_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_POP |-> count_q != '0)
    else $error("shift walk on an empty queue");

endmodule
`default_nettype wire

// ===== sv/tpq_store.sv =====
// Entry memory: one write port, one read port with registered read data.
`default_nettype none
module tpq_store #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 20
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// ===== sv/tpq_key_cmp.sv =====
// Sort key comparator: timestamp first, process id as tie-break.
`default_nettype none
module tpq_key_cmp #(
  parameter int unsigned TIME_BITS = 16
) (
  input  wire logic [TIME_BITS-1:0]      a_time_i,
  input  wire logic [tpq_pkg::PROC_W-1:0] a_proc_i,
  input  wire logic [TIME_BITS-1:0]      b_time_i,
  input  wire logic [tpq_pkg::PROC_W-1:0] b_proc_i,
  output      logic                      less_o
);

  import tpq_pkg::*;

  // a strictly before b
  always_comb begin
    if (a_time_i != b_time_i) begin
      less_o = (a_time_i < b_time_i);
    end else begin
      less_o = (a_proc_i < b_proc_i);
    end
  end

endmodule
`default_nettype wire
